### design/feha_pkg.sv
// Shared types, field widths and constants of the fire effect heat averager.
package feha_pkg;

  // Field widths of the request and result ports
  localparam int unsigned CMD_W      = 1;
  localparam int unsigned SEED_W     = 8;
  localparam int unsigned HEAT_W     = 7;
  localparam int unsigned CLASS_W    = 2;
  localparam int unsigned GLYPH_W    = 4;
  localparam int unsigned ROW_W      = 7;
  localparam int unsigned COL_W      = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned HGT_FLD_W  = 8;

  // Register power-on sizes (clamped to the frame limits at the top level)
  localparam int unsigned RESET_WIDTH  = 80;
  localparam int unsigned RESET_HEIGHT = 24;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_SEED    = 1'b0;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Heat levels
  localparam logic [HEAT_W-1:0] FULL_HEAT = 7'd65;
  localparam logic [HEAT_W-1:0] GLYPH_CAP = 7'd9;
  localparam logic [HEAT_W-1:0] HEAT_DIM  = 7'd4;
  localparam logic [HEAT_W-1:0] HEAT_WARM = 7'd9;
  localparam logic [HEAT_W-1:0] HEAT_HOT  = 7'd15;

  // Operation carried down the pipeline
  typedef enum logic [1:0] {
    OP_SEED,
    OP_ADVANCE,
    OP_PRIME
  } op_e;

  // Four-level color class of a heat value
  function automatic logic [CLASS_W-1:0] color_class_f(input logic [HEAT_W-1:0] h);
    logic [CLASS_W-1:0] c;
    if (h > HEAT_HOT) begin
      c = 2'd3;
    end else if (h > HEAT_WARM) begin
      c = 2'd2;
    end else if (h > HEAT_DIM) begin
      c = 2'd1;
    end else begin
      c = 2'd0;
    end
    return c;
  endfunction

  // Glyph index: heat capped at the glyph limit
  function automatic logic [GLYPH_W-1:0] glyph_f(input logic [HEAT_W-1:0] h);
    logic [HEAT_W-1:0] g;
    g = (h > GLYPH_CAP) ? GLYPH_CAP : h;
    return g[GLYPH_W-1:0];
  endfunction

endpackage

### design/feha_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
module feha_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read ports return the contents before a same-cycle write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### design/fire_effect_heat_averager.sv
// Fire effect heat averager: heat frame store with a three-stage update pipeline.
//
//   channel  | direction | handshake                  | payload
//   ---------+-----------+----------------------------+-------------------------------------
//   in       | request   | in_valid_i / in_stall_o    | command_i, seed_column_i
//   out      | result    | out_valid_o / out_stall_i  | heat_o, color_class_o, glyph_index_o,
//            |           |                            | row_o, column_o, drawn_o, frame_end_o
//   cfg      | write     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// One request per clock while in_stall_o is low. An advance gives its result from stage 3;
// a seed gives none. At the start of every frame the front issues a prime that loads the
// first two stored cells, as each advance reuses the two cells read by the one before.
// The heat store is swept to zero after reset and after every register write, one entry
// per cycle over all MAX_COLS*MAX_ROWS entries (32768 at the defaults), while requests wait.
// With a result held, out_stall_i freezes the pipeline and raises in_stall_o in the same cycle.
module fire_effect_heat_averager #(
  parameter int unsigned MAX_COLS = 256,
  parameter int unsigned MAX_ROWS = 128
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [feha_pkg::CMD_W-1:0]         command_i,
  input  logic [feha_pkg::SEED_W-1:0]        seed_column_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [feha_pkg::HEAT_W-1:0]        heat_o,
  output logic [feha_pkg::CLASS_W-1:0]       color_class_o,
  output logic [feha_pkg::GLYPH_W-1:0]       glyph_index_o,
  output logic [feha_pkg::ROW_W-1:0]         row_o,
  output logic [feha_pkg::COL_W-1:0]         column_o,
  output logic                               drawn_o,
  output logic                               frame_end_o,
  // register write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [feha_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [feha_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  import feha_pkg::*;

  localparam int unsigned DEPTH = MAX_COLS * MAX_ROWS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned IW    = AW + 1;                 // holds indexes past the frame
  localparam int unsigned CW    = $clog2(MAX_COLS + 1);
  localparam int unsigned HW    = $clog2(MAX_ROWS + 1);
  localparam int unsigned CLW   = $clog2(MAX_COLS);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned SW    = (CW > SEED_W) ? CW : SEED_W;
  localparam int unsigned RST_W = (RESET_WIDTH > MAX_COLS) ? MAX_COLS : RESET_WIDTH;
  localparam int unsigned RST_H = (RESET_HEIGHT > MAX_ROWS) ? MAX_ROWS : RESET_HEIGHT;

  // Frame size registers and derived sizes
  logic [CW-1:0] width_q;
  logic [HW-1:0] height_q;
  logic [IW-1:0] size_q;
  logic [AW-1:0] base_q;

  // Front control
  logic          clearing_q;
  logic [AW-1:0] clr_cnt_q;
  logic          primed_q;
  logic [AW-1:0] pos_q;
  logic [RW-1:0] row_q;
  logic [CLW-1:0] col_q;

  // Stage 1: addresses
  logic           s1_valid_q;
  op_e            s1_op_q;
  logic [AW-1:0]  s1_waddr_q;
  logic [IW-1:0]  s1_a1_q;
  logic [IW-1:0]  s1_a2_q;
  logic           s1_ok1_q;
  logic           s1_ok2_q;
  logic [RW-1:0]  s1_row_q;
  logic [CLW-1:0] s1_col_q;
  logic           s1_last_q;

  // Stage 2: read data
  logic           s2_valid_q;
  op_e            s2_op_q;
  logic [AW-1:0]  s2_waddr_q;
  logic [IW-1:0]  s2_a1_q;
  logic [IW-1:0]  s2_a2_q;
  logic           s2_ok1_q;
  logic           s2_ok2_q;
  logic [RW-1:0]  s2_row_q;
  logic [CLW-1:0] s2_col_q;
  logic           s2_last_q;

  // Stage 3: result register
  logic               s3_valid_q;
  logic [HEAT_W-1:0]  s3_heat_q;
  logic [CLASS_W-1:0] s3_class_q;
  logic [GLYPH_W-1:0] s3_glyph_q;
  logic [RW-1:0]      s3_row_q;
  logic [CLW-1:0]     s3_col_q;
  logic               s3_last_q;

  // Last write to the store, forwarded to the read one stage behind it
  logic              wb_valid_q;
  logic [AW-1:0]     wb_addr_q;
  logic [HEAT_W-1:0] wb_data_q;

  // Cells read by the previous advance: the next advance's own cell and the one below
  logic [HEAT_W-1:0] carry_self_q;
  logic [HEAT_W-1:0] carry_below_q;
  logic [IW-1:0]     carry_self_addr_q;
  logic [IW-1:0]     carry_below_addr_q;

  logic              en;
  logic              cfg_we;
  logic              issue_prime;
  logic              accept;
  logic              is_adv;
  logic              seed_ok;
  logic              last_cell;
  logic [AW-1:0]     seed_addr;
  logic [IW-1:0]     a1_next;
  logic [IW-1:0]     a2_next;
  logic [CW-1:0]     width_d;
  logic [HW-1:0]     height_d;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [HEAT_W-1:0] ram_wdata;
  logic              ram_re;
  logic [HEAT_W-1:0] rd_a;
  logic [HEAT_W-1:0] rd_b;

  logic [HEAT_W-1:0]   val1;
  logic [HEAT_W-1:0]   val2;
  logic [HEAT_W+1:0]   sum;
  logic [HEAT_W-1:0]   new_heat;
  logic                s2_write;
  logic [HEAT_W-1:0]   s2_wdata;
  logic [HEAT_W-1:0]   carry_self_d;
  logic [HEAT_W-1:0]   carry_below_d;
  logic [IW-1:0]       carry_self_addr_d;
  logic [IW-1:0]       carry_below_addr_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // Register value clamping
  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    if (32'(cfg_data_i) == 32'd0) begin
      width_d = CW'(1);
    end else if (32'(cfg_data_i) > MAX_COLS) begin
      width_d = CW'(MAX_COLS);
    end else begin
      width_d = CW'(cfg_data_i);
    end
    if (32'(cfg_data_i[HGT_FLD_W-1:0]) == 32'd0) begin
      height_d = HW'(1);
    end else if (32'(cfg_data_i[HGT_FLD_W-1:0]) > MAX_ROWS) begin
      height_d = HW'(MAX_ROWS);
    end else begin
      height_d = HW'(cfg_data_i[HGT_FLD_W-1:0]);
    end
  end

  // Size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CW'(RST_W);
      height_q <= HW'(RST_H);
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  width_q  <= width_d;
        REG_FRAME_HEIGHT: height_q <= height_d;
      endcase
    end
  end

  // Derived frame size and bottom row base, refreshed each cycle
  always_ff @(posedge clk_i) begin
    size_q <= IW'(width_q * height_q);
    base_q <= AW'(size_q - IW'(width_q));
  end

  // Front: request acceptance, prime issue and address generation
  assign en          = !(s3_valid_q && out_stall_i);
  assign issue_prime = en && !clearing_q && !primed_q;
  assign in_stall_o  = !en || clearing_q || !primed_q;
  assign accept      = in_valid_i && !in_stall_o;
  assign is_adv      = (command_i == CMD_ADVANCE);
  assign seed_ok     = SW'(seed_column_i) < SW'(width_q);
  assign seed_addr   = AW'(IW'(base_q) + IW'(seed_column_i));
  assign last_cell   = (row_q == RW'(height_q - HW'(1))) && (col_q == CLW'(width_q - CW'(1)));
  assign a1_next     = IW'(pos_q) + IW'(1);
  assign a2_next     = IW'(pos_q) + IW'(width_q) + IW'(1);

  // Cell position, clear sweep and prime tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      primed_q   <= 1'b0;
      pos_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
    end else if (cfg_we) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
      primed_q   <= 1'b0;
      pos_q      <= '0;
      row_q      <= '0;
      col_q      <= '0;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          clearing_q <= 1'b0;
        end
      end
      if (issue_prime) begin
        primed_q <= 1'b1;
      end else if (accept && is_adv) begin
        if (last_cell) begin
          primed_q <= 1'b0;
          pos_q    <= '0;
          row_q    <= '0;
          col_q    <= '0;
        end else begin
          pos_q <= pos_q + AW'(1);
          if (col_q == CLW'(width_q - CW'(1))) begin
            col_q <= '0;
            row_q <= row_q + RW'(1);
          end else begin
            col_q <= col_q + CLW'(1);
          end
        end
      end
    end
  end

  // Stage 1 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= issue_prime || (accept && (is_adv || seed_ok));
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_row_q  <= row_q;
      s1_col_q  <= col_q;
      s1_last_q <= last_cell;
      if (issue_prime) begin
        s1_op_q    <= OP_PRIME;
        s1_waddr_q <= '0;
        s1_a1_q    <= '0;
        s1_a2_q    <= IW'(width_q);
        s1_ok1_q   <= 1'b1;
        s1_ok2_q   <= (height_q != HW'(1));
      end else if (is_adv) begin
        s1_op_q    <= OP_ADVANCE;
        s1_waddr_q <= pos_q;
        s1_a1_q    <= a1_next;
        s1_a2_q    <= a2_next;
        s1_ok1_q   <= !last_cell;
        s1_ok2_q   <= (a2_next < size_q);
      end else begin
        s1_op_q    <= OP_SEED;
        s1_waddr_q <= seed_addr;
        s1_a1_q    <= '0;
        s1_a2_q    <= '0;
        s1_ok1_q   <= 1'b0;
        s1_ok2_q   <= 1'b0;
      end
    end
  end

  // Store reads issue as stage 1 moves on
  assign ram_re = en && s1_valid_q && (s1_op_q != OP_SEED);

  // Stage 2 valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // Stage 2 payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_op_q    <= s1_op_q;
      s2_waddr_q <= s1_waddr_q;
      s2_a1_q    <= s1_a1_q;
      s2_a2_q    <= s1_a2_q;
      s2_ok1_q   <= s1_ok1_q;
      s2_ok2_q   <= s1_ok2_q;
      s2_row_q   <= s1_row_q;
      s2_col_q   <= s1_col_q;
      s2_last_q  <= s1_last_q;
    end
  end

  // Stage 2: forward the write one ahead, mask cells past the frame, average
  always_comb begin
    val1 = '0;
    val2 = '0;
    if (s2_ok1_q) begin
      val1 = (wb_valid_q && (IW'(wb_addr_q) == s2_a1_q)) ? wb_data_q : rd_a;
    end
    if (s2_ok2_q) begin
      val2 = (wb_valid_q && (IW'(wb_addr_q) == s2_a2_q)) ? wb_data_q : rd_b;
    end
    sum = {2'b00, carry_self_q} + {2'b00, val1} + {2'b00, carry_below_q} + {2'b00, val2};
    new_heat = sum[HEAT_W+1:2];
  end

  // Stage 2: store write and carried cells
  always_comb begin
    s2_write           = 1'b0;
    s2_wdata           = new_heat;
    carry_self_d       = carry_self_q;
    carry_below_d      = carry_below_q;
    carry_self_addr_d  = carry_self_addr_q;
    carry_below_addr_d = carry_below_addr_q;
    case (s2_op_q)
      OP_SEED: begin
        s2_write = 1'b1;
        s2_wdata = FULL_HEAT;
        if (carry_self_addr_q == IW'(s2_waddr_q)) begin
          carry_self_d = FULL_HEAT;
        end
        if (carry_below_addr_q == IW'(s2_waddr_q)) begin
          carry_below_d = FULL_HEAT;
        end
      end
      OP_ADVANCE, OP_PRIME: begin
        s2_write           = (s2_op_q == OP_ADVANCE);
        carry_self_d       = val1;
        carry_below_d      = val2;
        carry_self_addr_d  = s2_a1_q;
        carry_below_addr_d = s2_a2_q;
      end
      default: begin
        s2_write = 1'b0;
      end
    endcase
  end

  // Carried cells
  always_ff @(posedge clk_i) begin
    if (en && s2_valid_q) begin
      carry_self_q       <= carry_self_d;
      carry_below_q      <= carry_below_d;
      carry_self_addr_q  <= carry_self_addr_d;
      carry_below_addr_q <= carry_below_addr_d;
    end
  end

  // Store write port: clear sweep or stage 2 write
  always_comb begin
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else begin
      ram_we    = en && s2_valid_q && s2_write;
      ram_waddr = s2_waddr_q;
      ram_wdata = s2_wdata;
    end
  end

  // Forwarding register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_valid_q <= 1'b0;
    end else if (clearing_q || cfg_we) begin
      wb_valid_q <= 1'b0;
    end else if (ram_we) begin
      wb_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      wb_addr_q <= ram_waddr;
      wb_data_q <= ram_wdata;
    end
  end

  // Heat store
  feha_ram #(
    .WIDTH (HEAT_W),
    .DEPTH (DEPTH)
  ) u_heat_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .re_i      (ram_re),
    .raddr_a_i (s1_a1_q[AW-1:0]),
    .raddr_b_i (s1_a2_q[AW-1:0]),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // Stage 3 valid: advances only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q && (s2_op_q == OP_ADVANCE);
    end
  end

  // Stage 3 payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_heat_q  <= new_heat;
      s3_class_q <= color_class_f(new_heat);
      s3_glyph_q <= glyph_f(new_heat);
      s3_row_q   <= s2_row_q;
      s3_col_q   <= s2_col_q;
      s3_last_q  <= s2_last_q;
    end
  end

  // Result outputs
  assign out_valid_o   = s3_valid_q;
  assign heat_o        = s3_heat_q;
  assign color_class_o = s3_class_q;
  assign glyph_index_o = s3_glyph_q;
  assign row_o         = ROW_W'(s3_row_q);
  assign column_o      = COL_W'(s3_col_q);
  assign drawn_o       = !s3_last_q;
  assign frame_end_o   = s3_last_q;

endmodule
